// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/bsed_pkg.sv =====
// ----------------------------------------------------------------------------
// bsed_pkg
// types, constants and helper functions of the backslash escape decoder
// ----------------------------------------------------------------------------
package bsed_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ESCAPES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE = 1'd1;

    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_NL  = 8'h0a;
    localparam logic [7:0] BYTE_VT  = 8'h0b;
    localparam logic [7:0] BYTE_FF  = 8'h0c;
    localparam logic [7:0] BYTE_CR  = 8'h0d;
    localparam logic [7:0] BYTE_ESC = 8'h1b;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] BYTE_BSL = 8'h5c;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       arg_end;
        logic       final_arg;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_beat;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_BSLASH = 4'b0010,
        PH_HEX    = 4'b0100,
        PH_OCT    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic                        snl;
        logic                        stop;
    } t_emit;

    function automatic t_emit f_emit(t_emit e, logic [7:0] b);
        t_emit r;
        r = e;
        if (!r.stop && (r.cnt < CNT_W'(MAX_RESULTS))) begin
            r.bytes[r.cnt[IDX_W-1:0]] = b;
            r.cnt = r.cnt + CNT_W'(1);
            r.snl = (b == BYTE_NL);
        end
        return r;
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] f_hex_digit(logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b inside {["0":"9"]}) begin
            r = {1'b1, 4'(b - "0")};
        end else if (b inside {["a":"f"]}) begin
            r = {1'b1, 4'(b - "a" + 8'd10)};
        end else if (b inside {["A":"F"]}) begin
            r = {1'b1, 4'(b - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/backslash_escape_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// backslash_escape_decoder_unit
// decodes a stream of argument bytes into printable output bytes
// ----------------------------------------------------------------------------
// An input beat is taken in every cycle as long as each one yields at most one
// output byte and the output is not stalled; a beat that yields k bytes (up to
// four, e.g. a pending escape flushed at an argument end plus the separator)
// holds the single output byte lane until all k are sent. The decoder itself
// is one pass of logic into a burst register, which is handed to the output
// register when that drains. The configuration port is always ready; the user
// must write it only while the block is idle, which the block does not enforce.
module backslash_escape_decoder_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  bsed_pkg::t_in_beat                 i_in_beat,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output bsed_pkg::t_out_beat                o_out_beat,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bsed_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic                               i_cfg_data
);
    import bsed_pkg::*;

    logic                        r_esc_en;
    logic                        r_tnl;
    t_phase                      r_phase;
    logic [7:0]                  r_val;
    logic [1:0]                  r_left;
    logic                        r_snl;
    logic                        r_stopped;

    logic [MAX_RESULTS-1:0][7:0] r_b_bytes;
    logic [CNT_W-1:0]            r_b_cnt;
    logic [MAX_RESULTS-1:0][7:0] r_o_bytes;
    logic [CNT_W-1:0]            r_o_cnt;
    logic [IDX_W-1:0]            r_o_idx;

    t_phase                      n_phase;
    logic [7:0]                  n_val;
    logic [1:0]                  n_left;
    t_emit                       n_emit;

    logic [7:0]                  in_b;
    logic [4:0]                  hx;
    logic                        o_last;
    logic                        o_free;
    logic                        in_acc;

    assign in_b = i_in_beat.in_byte;
    assign hx   = f_hex_digit(in_b);

    // decode
    always_comb begin
        n_emit = '{bytes: '0, cnt: '0, snl: r_snl, stop: r_stopped};
        n_phase = r_phase;
        n_val = r_val;
        n_left = r_left;
        case (r_phase)
            PH_IDLE: begin
                if (r_esc_en && (in_b == BYTE_BSL)) begin
                    n_phase = PH_BSLASH;
                end else begin
                    n_emit = f_emit(n_emit, in_b);
                end
            end
            PH_BSLASH: begin
                n_phase = PH_IDLE;
                case (in_b)
                    "a": n_emit = f_emit(n_emit, BYTE_BEL);
                    "b": n_emit = f_emit(n_emit, BYTE_BS);
                    "c": n_emit.stop = 1'b1;
                    "e": n_emit = f_emit(n_emit, BYTE_ESC);
                    "f": n_emit = f_emit(n_emit, BYTE_FF);
                    "n": n_emit = f_emit(n_emit, BYTE_NL);
                    "r": n_emit = f_emit(n_emit, BYTE_CR);
                    "t": n_emit = f_emit(n_emit, BYTE_TAB);
                    "v": n_emit = f_emit(n_emit, BYTE_VT);
                    BYTE_BSL: n_emit = f_emit(n_emit, BYTE_BSL);
                    "x": begin
                        n_phase = PH_HEX;
                        n_val = '0;
                        n_left = 2'd2;
                    end
                    "0": begin
                        n_phase = PH_OCT;
                        n_val = '0;
                        n_left = 2'd3;
                    end
                    "1", "2", "3", "4", "5", "6", "7": begin
                        n_phase = PH_OCT;
                        n_val = {5'd0, in_b[2:0]};
                        n_left = 2'd2;
                    end
                    default: begin
                        n_emit = f_emit(n_emit, BYTE_BSL);
                        n_emit = f_emit(n_emit, in_b);
                    end
                endcase
            end
            PH_HEX: begin
                if (hx[4]) begin
                    n_val = {r_val[3:0], hx[3:0]};
                    n_left = r_left - 2'd1;
                    if (n_left == 2'd0) begin
                        n_emit = f_emit(n_emit, n_val);
                        n_phase = PH_IDLE;
                        n_val = '0;
                    end
                end else begin
                    if (r_left == 2'd2) begin
                        n_emit = f_emit(n_emit, BYTE_BSL);
                        n_emit = f_emit(n_emit, "x");
                    end else begin
                        n_emit = f_emit(n_emit, r_val);
                    end
                    n_val = '0;
                    n_left = '0;
                    n_phase = PH_IDLE;
                    if (r_esc_en && (in_b == BYTE_BSL)) begin
                        n_phase = PH_BSLASH;
                    end else begin
                        n_emit = f_emit(n_emit, in_b);
                    end
                end
            end
            PH_OCT: begin
                if (in_b inside {["0":"7"]}) begin
                    n_val = {r_val[4:0], in_b[2:0]};
                    n_left = r_left - 2'd1;
                    if (n_left == 2'd0) begin
                        n_emit = f_emit(n_emit, n_val);
                        n_phase = PH_IDLE;
                        n_val = '0;
                    end
                end else begin
                    n_emit = f_emit(n_emit, r_val);
                    n_val = '0;
                    n_left = '0;
                    n_phase = PH_IDLE;
                    if (r_esc_en && (in_b == BYTE_BSL)) begin
                        n_phase = PH_BSLASH;
                    end else begin
                        n_emit = f_emit(n_emit, in_b);
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // argument end: flush pending escape, then separator or newline
        if (i_in_beat.arg_end) begin
            case (n_phase)
                PH_BSLASH: n_emit = f_emit(n_emit, BYTE_BSL);
                PH_HEX: begin
                    if (n_left == 2'd2) begin
                        n_emit = f_emit(n_emit, BYTE_BSL);
                        n_emit = f_emit(n_emit, "x");
                    end else begin
                        n_emit = f_emit(n_emit, n_val);
                    end
                end
                PH_OCT: n_emit = f_emit(n_emit, n_val);
                default: begin
                end
            endcase
            n_phase = PH_IDLE;
            n_val = '0;
            n_left = '0;
            if (i_in_beat.final_arg) begin
                if (r_tnl) begin
                    n_emit = f_emit(n_emit, BYTE_NL);
                end
                n_emit.stop = 1'b0;
                n_emit.snl = 1'b0;
            end else if (!n_emit.snl) begin
                n_emit = f_emit(n_emit, BYTE_SP);
            end
        end
    end

    // handshake
    assign o_out_valid = (r_o_cnt != '0);
    assign o_last      = ({1'b0, r_o_idx} == (r_o_cnt - CNT_W'(1)));
    assign o_free      = !o_out_valid || (o_last && !i_out_stall);
    assign o_in_stall  = (r_b_cnt != '0) && !o_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_beat.out_byte = r_o_bytes[r_o_idx];
    assign o_out_beat.run_last = o_last;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_en <= 1'b0;
            r_tnl <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ESCAPES: r_esc_en <= i_cfg_data;
                REG_NEWLINE: r_tnl <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // decoder state and burst register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_val <= '0;
            r_left <= '0;
            r_snl <= 1'b0;
            r_stopped <= 1'b0;
            r_b_cnt <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_val <= n_val;
            r_left <= n_left;
            r_snl <= n_emit.snl;
            r_stopped <= n_emit.stop;
            r_b_cnt <= n_emit.cnt;
        end else if (o_free) begin
            r_b_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_bytes <= n_emit.bytes;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_cnt <= '0;
            r_o_idx <= '0;
        end else if (o_free) begin
            r_o_cnt <= r_b_cnt;
            r_o_idx <= '0;
        end else if (!i_out_stall) begin
            r_o_idx <= r_o_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_o_bytes <= r_b_bytes;
        end
    end

endmodule

// ===== rtl/bsed_checker.sv =====
// ----------------------------------------------------------------------------
// bsed_checker
// port-level checks of the backslash escape decoder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsed_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  bsed_pkg::t_in_beat             i_in_beat,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  bsed_pkg::t_out_beat            o_out_beat,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready
);
    import bsed_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // held output beat stays put
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_beat))

    // held input beat stays put
    `AST_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_in_beat))

    // input only backs up behind a pending output
    `AST_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // a fresh output burst comes from a beat taken through the burst register
    `AST_IMPLY(a_burst_src, i_clk, i_rst_n, $rose(o_out_valid), $past(in_acc, 2))

    // register writes are never held off
    `AST_IMPLY(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind backslash_escape_decoder_unit bsed_checker u_bsed_checker (.*);

// ===== sim/backslash_escape_decoder_unit_checker.sv =====
// ----------------------------------------------------------------------------
// backslash escape decoder checker
// watches the input, output and register write channels of the decoder,
// works out the output beats each input beat must produce and compares them
// in order against the beats the decoder delivers
// ----------------------------------------------------------------------------
module backslash_escape_decoder_unit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  bsed_pkg::t_in_beat             i_in_beat,
    input  logic                           i_in_stall,
    input  logic                           i_out_valid,
    input  bsed_pkg::t_out_beat            i_out_beat,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bsed_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data,
    output int                             o_mismatches,
    output int                             o_bytes_owed,
    output int                             o_bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import bsed_pkg::*;

    t_phase     esc_phase   = PH_IDLE;
    logic [7:0] esc_value   = '0;
    logic [1:0] digits_left = '0;
    logic       sent_nl     = 1'b0;
    logic       out_stopped = 1'b0;
    logic       cfg_escapes = 1'b0;
    logic       cfg_newline = 1'b1;

    logic [7:0] burst [MAX_RESULTS];
    int         burst_len;
    t_out_beat  owed_beats [$];
    int         mismatches = 0;
    int         checked    = 0;

    function automatic void emit_byte(logic [7:0] b);
        if (!out_stopped && burst_len < MAX_RESULTS) begin
            burst[burst_len] = b;
            burst_len++;
            sent_nl = (b == BYTE_NL);
        end
    endfunction

    function automatic void clear_escape();
        esc_phase   = PH_IDLE;
        esc_value   = '0;
        digits_left = '0;
    endfunction

    function automatic logic hex_value(input logic [7:0] b, output logic [3:0] d);
        logic [7:0] lc;
        lc = b | 8'h20;
        d  = '0;
        if (b >= "0" && b <= "9") begin
            d = 4'(b - "0");
            return 1'b1;
        end
        if (lc >= "a" && lc <= "f") begin
            d = 4'(lc - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void plain_byte(logic [7:0] b);
        if (cfg_escapes && b == BYTE_BSL) begin
            esc_phase = PH_BSLASH;
        end else begin
            emit_byte(b);
        end
    endfunction

    // pending escape cut short: bare \x gives its two bytes back
    function automatic void flush_escape();
        case (esc_phase)
            PH_BSLASH: emit_byte(BYTE_BSL);
            PH_HEX: begin
                if (digits_left == 2'd2) begin
                    emit_byte(BYTE_BSL);
                    emit_byte("x");
                end else begin
                    emit_byte(esc_value);
                end
            end
            PH_OCT: emit_byte(esc_value);
            default: ;
        endcase
        clear_escape();
    endfunction

    function automatic void escape_letter(logic [7:0] b);
        esc_phase = PH_IDLE;
        case (b)
            "a": emit_byte(BYTE_BEL);
            "b": emit_byte(BYTE_BS);
            "c": out_stopped = 1'b1;
            "e": emit_byte(BYTE_ESC);
            "f": emit_byte(BYTE_FF);
            "n": emit_byte(BYTE_NL);
            "r": emit_byte(BYTE_CR);
            "t": emit_byte(BYTE_TAB);
            "v": emit_byte(BYTE_VT);
            BYTE_BSL: emit_byte(BYTE_BSL);
            "x": begin
                esc_phase   = PH_HEX;
                esc_value   = '0;
                digits_left = 2'd2;
            end
            "0": begin
                esc_phase   = PH_OCT;
                esc_value   = '0;
                digits_left = 2'd3;
            end
            "1", "2", "3", "4", "5", "6", "7": begin
                esc_phase   = PH_OCT;
                esc_value   = b - "0";
                digits_left = 2'd2;
            end
            default: begin
                emit_byte(BYTE_BSL);
                emit_byte(b);
            end
        endcase
    endfunction

    function automatic void decode_beat(t_in_beat beat);
        logic [7:0] b;
        logic [3:0] d;
        t_out_beat  ob;
        b = beat.in_byte;
        burst_len = 0;
        case (esc_phase)
            PH_BSLASH: escape_letter(b);
            PH_HEX: begin
                if (hex_value(b, d)) begin
                    esc_value   = esc_value * 8'd16 + {4'd0, d};
                    digits_left = digits_left - 2'd1;
                    if (digits_left == 2'd0) begin
                        emit_byte(esc_value);
                        clear_escape();
                    end
                end else begin
                    flush_escape();
                    plain_byte(b);
                end
            end
            PH_OCT: begin
                if (b >= "0" && b <= "7") begin
                    esc_value   = esc_value * 8'd8 + (b - "0");
                    digits_left = digits_left - 2'd1;
                    if (digits_left == 2'd0) begin
                        emit_byte(esc_value);
                        clear_escape();
                    end
                end else begin
                    flush_escape();
                    plain_byte(b);
                end
            end
            default: plain_byte(b);
        endcase
        if (beat.arg_end) begin
            flush_escape();
            if (beat.final_arg) begin
                if (cfg_newline) begin
                    emit_byte(BYTE_NL);
                end
                out_stopped = 1'b0;
                sent_nl     = 1'b0;
            end else if (!sent_nl) begin
                emit_byte(BYTE_SP);
            end
        end
        for (int i = 0; i < burst_len; i++) begin
            ob.out_byte = burst[i];
            ob.run_last = (i == burst_len - 1);
            owed_beats.push_back(ob);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            clear_escape();
            sent_nl     = 1'b0;
            out_stopped = 1'b0;
            cfg_escapes = 1'b0;
            cfg_newline = 1'b1;
            owed_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ESCAPES: cfg_escapes = i_cfg_data;
                    REG_NEWLINE: cfg_newline = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                decode_beat(i_in_beat);
            end
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (owed_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected output beat: byte %02h last %0b",
                                 i_out_beat.out_byte, i_out_beat.run_last);
                    end
                end else begin
                    want = owed_beats.pop_front();
                    if (i_out_beat.out_byte !== want.out_byte ||
                        i_out_beat.run_last !== want.run_last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("output beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                     checked, want.out_byte, want.run_last,
                                     i_out_beat.out_byte, i_out_beat.run_last);
                        end
                    end
                end
            end
        end
        o_mismatches    <= mismatches;
        o_bytes_owed    <= owed_beats.size();
        o_bytes_checked <= checked;
    end

endmodule

// ===== sim/backslash_escape_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// backslash escape decoder testbench
// feeds argument bytes grouped into commands, first a short directed run over
// the escape forms, then random commands under three stall patterns and three
// register settings; the checker beside the decoder predicts every output beat
// ----------------------------------------------------------------------------
module backslash_escape_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsed_pkg::*;

    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int OUT_HOLD_CYCLES = 150;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_beat             in_beat   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_beat            out_beat;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ESCAPES;
    logic                 cfg_data  = 1'b0;

    int    mismatches;
    int    bytes_owed;
    int    bytes_checked;
    int    beats_sent    = 0;
    int    commands_sent = 0;
    int    idle_cycles   = 0;
    int    snd_idle_pct  = 0;
    int    rcv_idle_pct  = 0;
    bit    hold_req      = 1'b0;
    bit    hold_done     = 1'b0;
    string escape_letters = "abcefnrtvx\\";
    string digit_chars    = "0123456789abcdefABCDEFgG";

    backslash_escape_decoder_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_beat   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    backslash_escape_decoder_unit_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_beat       (in_beat),
        .i_in_stall      (in_stall),
        .i_out_valid     (out_valid),
        .i_out_beat      (out_beat),
        .i_out_stall     (out_stall),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_bytes_owed    (bytes_owed),
        .o_bytes_checked (bytes_checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side, with one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (OUT_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic send_beat(input t_in_beat beat);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic send_chars(input string s, input logic ends, input logic last_arg);
        t_in_beat beat;
        for (int k = 0; k < s.len(); k++) begin
            beat.in_byte   = s[k];
            beat.arg_end   = ends && (k == s.len() - 1);
            beat.final_arg = last_arg;
            send_beat(beat);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0, 1, 2: return BYTE_BSL;
            3, 4:    return escape_letters[$urandom_range(escape_letters.len() - 1)];
            5, 6:    return digit_chars[$urandom_range(digit_chars.len() - 1)];
            7, 8:    return 8'($urandom_range(32, 126));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed commands, some with random bytes and flags
    task automatic send_command();
        int       nargs;
        int       len;
        logic     noisy;
        t_in_beat beat;
        nargs = $urandom_range(1, 3);
        noisy = ($urandom_range(4) == 0);
        for (int a = 0; a < nargs; a++) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                beat.in_byte   = noisy ? 8'($urandom_range(255)) : pick_byte();
                beat.arg_end   = (k == len - 1);
                beat.final_arg = (a == nargs - 1);
                if (noisy && !(beat.arg_end && beat.final_arg)) begin
                    beat.arg_end   = ($urandom_range(3) == 0);
                    beat.final_arg = $urandom_range(1);
                end
                send_beat(beat);
            end
        end
        commands_sent++;
    endtask

    task automatic send_commands(input int n);
        int target;
        target = beats_sent + n;
        while (beats_sent < target) begin
            send_command();
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (bytes_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic escapes, input logic newline);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ESCAPES;
        cfg_data  <= escapes;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_NEWLINE;
        cfg_data  <= newline;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        snd_idle_pct = 9;
        rcv_idle_pct = 57;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!rst_n);

        set_config(1'b1, 1'b1);
        send_beat('{in_byte: 8'h00, arg_end: 1'b0, final_arg: 1'b0});
        send_beat('{in_byte: 8'hff, arg_end: 1'b1, final_arg: 1'b0});
        send_chars("\\n", 1'b1, 1'b0);
        send_chars("\\777\\xFg\\x", 1'b1, 1'b0);
        send_chars("\\q\\", 1'b1, 1'b0);
        send_chars("\\0123\\cz", 1'b1, 1'b1);
        commands_sent++;
        drain();

        send_commands(150);
        drain();

        set_config(1'b1, 1'b0);
        snd_idle_pct = 57;
        rcv_idle_pct = 9;
        send_commands(130);
        // hex escape left open across a register write
        send_chars("\\x4", 1'b0, 1'b0);
        drain();

        set_config(1'b0, 1'b0);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_chars("1", 1'b1, 1'b1);
        commands_sent++;
        send_commands(50);
        drain();

        set_config(1'b1, 1'b1);
        hold_req = 1'b1;
        send_commands(70);
        drain();

        $display("%0d input beats in %0d commands, %0d output beats compared",
                 beats_sent, commands_sent, bytes_checked);
        $display("escapes on and off, trailing newline on and off, stalls on both sides");
        if (mismatches == 0 && bytes_owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
